// ----- rtl/swgf_pkg.sv -----
// Package for the sliding window glitch flagger.
// Holds register index codes, field widths and reset constants; no dependencies.
`default_nettype none

package swgf_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int THRESH_W    = 16;
    localparam int RADIUS_W    = 4;
    localparam int MIN_GOOD_W  = 5;

    localparam logic [RADIUS_W-1:0] DEFAULT_RADIUS = RADIUS_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BAD_VALUE = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_RADIUS    = 2'd2,
        REG_MIN_GOOD  = 2'd3
    } swgf_reg_t;

endpackage

`default_nettype wire

// ----- rtl/swgf_if.sv -----
// Handshake channels of the glitch flagger: gate items, result items, register writes.
// Depends on swgf_pkg.
`default_nettype none

interface swgf_gate_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          in_boundary;
    logic                          ray_start;

    modport source (output valid, sample, in_boundary, ray_start, input ready);
    modport sink   (input valid, sample, in_boundary, ray_start, output ready);
endinterface

interface swgf_result_if;
    logic valid;
    logic ready;
    logic flagged;
    logic tested;

    modport source (output valid, flagged, tested, input ready);
    modport sink   (input valid, flagged, tested, output ready);
endinterface

interface swgf_cfg_if #(parameter int DATA_W = 16);
    import swgf_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/sliding_window_glitch_flagger_core.sv -----
// Sliding window glitch flagger, top level.
// Depends on swgf_pkg and the channel interfaces in swgf_if.sv.
//
// Usage:
//   gate   : one radar gate item per handshake (sample, in_boundary, ray_start).
//   result : one item per accepted gate: flagged/tested for the gate radius
//            positions earlier in the window (both 0 where no test is made).
//   cfg    : register writes (0 bad_value, 1 threshold, 2 radius, 3 min_good),
//            always ready; write only while the block is idle. Writing radius
//            restarts the window.
// Throughput: one item per cycle while result is ready. Path: an accepted gate
//   is registered in the update stage and then in the result register, which
//   drives result.valid. Samples sit in a window memory with one write
//   port and two registered read ports (oldest entry and center); the good
//   bits, running sum and good count are read, updated and written back in a
//   single stage, which sets the clock rate: sum update, a 6x16 and a 16x5
//   multiply side by side, subtract and compare.
// Reset: registers go to their reset values and the window is empty; the
//   sample memory is not cleared, entries are only read after being written.
// Stall: when result is not ready, the result register and the update stage
//   hold and gate.ready drops once both are full; no item is lost.
`default_nettype none

module sliding_window_glitch_flagger_core #(
    parameter int MAX_RADIUS  = 15,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    swgf_gate_if.sink   gate,
    swgf_result_if.source result,
    swgf_cfg_if.sink    cfg
);
    import swgf_pkg::*;

    localparam int DEPTH  = 2 * MAX_RADIUS + 1;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int RW     = $clog2(MAX_RADIUS + 1);
    localparam int RXW    = (RW > RADIUS_W) ? RW : RADIUS_W;
    localparam int MGW    = (CW > MIN_GOOD_W) ? CW : MIN_GOOD_W;
    localparam int SUM_W  = SAMPLE_BITS + CW;
    localparam int DEV_W  = SUM_W + 2;
    localparam int LIM_W  = THRESH_W + CW;
    localparam int CMP_W  = (DEV_W > LIM_W) ? DEV_W : LIM_W;
    localparam logic [RXW-1:0] MAX_R = RXW'(MAX_RADIUS);

    // configuration registers
    logic signed [SAMPLE_BITS-1:0] bad_value_reg;
    logic [THRESH_W-1:0]           threshold_reg;
    logic [RADIUS_W-1:0]           radius_reg;
    logic [MIN_GOOD_W-1:0]         min_good_reg;
    logic                          cfg_wr;
    logic                          radius_wr;

    // effective window geometry
    logic [RXW-1:0] r_raw;
    logic [RW-1:0]  r_eff;
    logic [CW-1:0]  navg;
    logic [CW-1:0]  test_min;

    // front stage
    logic [AW-1:0] wp_reg, wp_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          accept;
    logic          clear0;
    logic [AW-1:0] w0, c0;
    logic [CW-1:0] fill0, fill_after;
    logic          full0;

    // window memory
    logic [SAMPLE_BITS-1:0]        mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_old_reg;
    logic signed [SAMPLE_BITS-1:0] rd_ctr_reg;

    // update stage
    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_clear_reg, s1_inb_reg, s1_good_reg;
    logic                          s1_full_reg, s1_test_reg;
    logic signed [SAMPLE_BITS-1:0] s1_x_reg;
    logic [AW-1:0]                 s1_w_reg, s1_c_reg;
    logic                          s1_fire;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [DEPTH-1:0]        good_reg, good_next;

    logic signed [SUM_W-1:0] sum_b;
    logic [CW-1:0]           cnt_b;
    logic [DEPTH-1:0]        good_b;
    logic                    do_test;
    logic signed [CW:0]      n_s;
    logic signed [DEV_W-1:0] prod;
    logic signed [DEV_W-1:0] dev;
    logic [CMP_W-1:0]        abs_dev;
    logic [CMP_W-1:0]        lim;
    logic                    flag;

    // result register
    logic out_valid_reg, out_valid_next;
    logic flagged_reg, tested_reg;
    logic out_free;

    // configuration
    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;
    assign radius_wr = cfg_wr && (swgf_reg_t'(cfg.index) == REG_RADIUS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bad_value_reg <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            threshold_reg <= '0;
            radius_reg    <= DEFAULT_RADIUS;
            min_good_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (swgf_reg_t'(cfg.index))
                REG_BAD_VALUE: bad_value_reg <= cfg.data[SAMPLE_BITS-1:0];
                REG_THRESHOLD: threshold_reg <= cfg.data[THRESH_W-1:0];
                REG_RADIUS:    radius_reg    <= cfg.data[RADIUS_W-1:0];
                REG_MIN_GOOD:  min_good_reg  <= cfg.data[MIN_GOOD_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        r_raw = (radius_reg == '0) ? RXW'(DEFAULT_RADIUS) : RXW'(radius_reg);
        r_eff = RW'((r_raw > MAX_R) ? MAX_R : r_raw);
        navg  = CW'({r_eff, 1'b1});
        if ((min_good_reg == '0) || (MGW'(min_good_reg) > MGW'(navg)))
            test_min = navg;
        else
            test_min = CW'(min_good_reg);
    end

    // front stage: address generation and fill tracking
    assign out_free   = !out_valid_reg || result.ready;
    assign s1_fire    = s1_valid_reg && out_free;
    assign gate.ready = !s1_valid_reg || out_free;
    assign accept     = gate.valid && gate.ready;

    always_comb
    begin
        clear0     = gate.ray_start || !gate.in_boundary;
        w0         = clear0 ? '0 : wp_reg;
        fill0      = clear0 ? '0 : fill_reg;
        full0      = (fill0 >= navg);
        fill_after = full0 ? navg : fill0 + CW'(1);
        if (w0 >= AW'(r_eff))
            c0 = w0 - AW'(r_eff);
        else
            c0 = AW'(CW'(w0) + navg - CW'(r_eff));

        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (radius_wr)
        begin
            wp_next   = '0;
            fill_next = '0;
        end
        else if (accept)
        begin
            if (gate.in_boundary)
            begin
                wp_next   = (CW'(w0) + CW'(1) == navg) ? '0 : w0 + AW'(1);
                fill_next = fill_after;
            end
            else
            begin
                wp_next   = '0;
                fill_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
        end
    end

    // window memory: read-first, oldest entry and center read at accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (gate.in_boundary)
                mem[w0] <= gate.sample;
            rd_old_reg <= mem[w0];
            rd_ctr_reg <= mem[c0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_clear_reg <= clear0;
            s1_inb_reg   <= gate.in_boundary;
            s1_good_reg  <= (gate.sample != bad_value_reg);
            s1_full_reg  <= full0;
            s1_test_reg  <= gate.in_boundary && (fill_after > CW'(r_eff));
            s1_x_reg     <= gate.sample;
            s1_w_reg     <= w0;
            s1_c_reg     <= c0;
        end
    end

    // update stage: sum, count and good bits read, modified, written back
    always_comb
    begin
        good_b = s1_clear_reg ? '0 : good_reg;
        sum_b  = s1_clear_reg ? '0 : sum_reg;
        cnt_b  = s1_clear_reg ? '0 : cnt_reg;
        if (s1_inb_reg)
        begin
            if (s1_full_reg && good_b[s1_w_reg])
            begin
                sum_b = sum_b - SUM_W'(rd_old_reg);
                cnt_b = cnt_b - CW'(1);
            end
            good_b[s1_w_reg] = s1_good_reg;
            if (s1_good_reg)
            begin
                sum_b = sum_b + SUM_W'(s1_x_reg);
                cnt_b = cnt_b + CW'(1);
            end
        end

        do_test = s1_test_reg && (cnt_b >= test_min) && good_b[s1_c_reg];
        n_s     = {1'b0, cnt_b};
        prod    = DEV_W'(n_s) * DEV_W'(rd_ctr_reg);
        dev     = DEV_W'(sum_b) - prod;
        abs_dev = CMP_W'(dev[DEV_W-1] ? -dev : dev);
        lim     = CMP_W'(LIM_W'(threshold_reg) * LIM_W'(cnt_b - CW'(1)));
        flag    = do_test && (abs_dev > lim);

        if (flag)
        begin
            sum_b            = sum_b - SUM_W'(rd_ctr_reg);
            cnt_b            = cnt_b - CW'(1);
            good_b[s1_c_reg] = 1'b0;
        end

        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        good_next = good_reg;
        if (radius_wr)
        begin
            sum_next  = '0;
            cnt_next  = '0;
            good_next = '0;
        end
        else if (s1_fire)
        begin
            sum_next  = sum_b;
            cnt_next  = cnt_b;
            good_next = good_b;
        end

        s1_valid_next = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_fire ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            cnt_reg       <= '0;
            good_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            good_reg      <= good_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            flagged_reg <= flag;
            tested_reg  <= do_test;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.flagged = flagged_reg;
    assign result.tested  = tested_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= navg)
        else $error("fill count exceeds window length");

    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(wp_reg) < navg)
        else $error("write position outside window");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("good count exceeds store depth");

    a_flag_tested: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!flagged_reg || tested_reg))
        else $error("flagged result without test");

    a_boundary_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !gate.in_boundary) |=> (fill_reg == '0 && wp_reg == '0))
        else $error("window not restarted after out-of-boundary item");

endmodule

`default_nettype wire

// ----- tb/swgf_flag_checker.sv -----
// Scoreboard for the sliding window glitch flagger: tracks register writes and gate items,
// predicts the flagged/tested result of each gate and compares it with the result channel.
// Depends on swgf_pkg.
module swgf_flag_checker #(
    parameter int MAX_RADIUS = 15
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           gate_valid,
    input  logic                           gate_ready,
    input  logic signed [15:0]             gate_sample,
    input  logic                           gate_in_boundary,
    input  logic                           gate_ray_start,
    input  logic                           result_valid,
    input  logic                           result_ready,
    input  logic                           result_flagged,
    input  logic                           result_tested,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [swgf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import swgf_pkg::*;

    localparam int DEPTH         = 2 * MAX_RADIUS + 1;
    localparam int ERR_PRINT_MAX = 60;

    typedef struct packed {
        logic flagged;
        logic tested;
    } flag_item_t;

    logic signed [15:0]    bad_code;
    logic [THRESH_W-1:0]   thresh;
    logic [RADIUS_W-1:0]   rad_reg;
    logic [MIN_GOOD_W-1:0] min_good_reg;

    logic signed [15:0] window_vals [DEPTH];
    logic               window_ok   [DEPTH];
    logic [4:0]         wr_pos;
    logic [4:0]         filled;
    logic [4:0]         good_cnt;
    logic signed [21:0] window_sum;

    flag_item_t expected_flags [$];
    flag_item_t want;

    function automatic void clear_window();
        for (int i = 0; i < DEPTH; i++)
        begin
            window_vals[i] = '0;
            window_ok[i]   = 1'b0;
        end
        wr_pos     = '0;
        filled     = '0;
        good_cnt   = '0;
        window_sum = '0;
    endfunction

    function automatic flag_item_t predict_flags(input logic signed [15:0] x,
                                                 input logic inb, input logic rs);
        int                 r;
        int                 navg;
        int                 test_min;
        int                 w;
        int                 c;
        logic               g;
        logic signed [39:0] n;
        logic signed [39:0] cv;
        logic signed [39:0] dev;
        logic signed [39:0] lim;
        flag_item_t         res;

        res = '0;
        r = (rad_reg == '0) ? int'(DEFAULT_RADIUS) : int'(rad_reg);
        if (r > MAX_RADIUS)
            r = MAX_RADIUS;
        navg = 2 * r + 1;
        test_min = int'(min_good_reg);
        if (test_min < 1 || test_min > navg)
            test_min = navg;

        if (rs || !inb)
            clear_window();

        if (inb)
        begin
            w = int'(wr_pos);
            g = (x != bad_code);
            // drop the oldest entry once the window is full
            if (int'(filled) >= navg && window_ok[w])
            begin
                window_sum = window_sum - window_vals[w];
                good_cnt   = good_cnt - 5'd1;
            end
            window_vals[w] = x;
            window_ok[w]   = g;
            if (g)
            begin
                window_sum = window_sum + x;
                good_cnt   = good_cnt + 5'd1;
            end
            if (int'(filled) < navg)
                filled = filled + 5'd1;

            if (int'(filled) > r)
            begin
                c = (w + navg - r) % navg;
                if (int'(good_cnt) >= test_min && window_ok[c])
                begin
                    n   = $signed({35'd0, good_cnt});
                    cv  = window_vals[c];
                    dev = window_sum - n * cv;
                    lim = $signed({24'd0, thresh}) * (n - 40'sd1);
                    if (dev < 0)
                        dev = -dev;
                    res.tested = 1'b1;
                    if (dev > lim)
                    begin
                        res.flagged = 1'b1;
                        window_sum  = window_sum - window_vals[c];
                        good_cnt    = good_cnt - 5'd1;
                        window_ok[c] = 1'b0;
                    end
                end
            end
            wr_pos = 5'((w + 1) % navg);
        end
        return res;
    endfunction

    function automatic void note_mismatch(input string field, input logic want_bit,
                                          input logic got_bit);
        if (fail_count < ERR_PRINT_MAX)
            $error("%s: expected %0b, actual %0b", field, want_bit, got_bit);
        fail_count++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bad_code     = 16'sh8000;
            thresh       = '0;
            rad_reg      = DEFAULT_RADIUS;
            min_good_reg = '0;
            clear_window();
            expected_flags.delete();
            fail_count   = 0;
            pending      = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (swgf_reg_t'(cfg_index))
                    REG_BAD_VALUE: bad_code = cfg_data;
                    REG_THRESHOLD: thresh   = cfg_data;
                    REG_RADIUS:
                    begin
                        rad_reg = cfg_data[RADIUS_W-1:0];
                        clear_window();
                    end
                    REG_MIN_GOOD:  min_good_reg = cfg_data[MIN_GOOD_W-1:0];
                    default: ;
                endcase
            end

            if (gate_valid && gate_ready)
                expected_flags.push_back(predict_flags(gate_sample, gate_in_boundary,
                                                       gate_ray_start));

            if (result_valid && result_ready)
            begin
                if (expected_flags.size() == 0)
                begin
                    if (fail_count < ERR_PRINT_MAX)
                        $error("result item with no gate item waiting");
                    fail_count++;
                end
                else
                begin
                    want = expected_flags.pop_front();
                    if (result_flagged !== want.flagged)
                        note_mismatch("flagged", want.flagged, result_flagged);
                    if (result_tested !== want.tested)
                        note_mismatch("tested", want.tested, result_tested);
                end
            end
            pending = expected_flags.size();
        end
    end

endmodule

// ----- tb/tb_sliding_window_glitch_flagger_core.sv -----
// Top of the glitch flagger testbench: clock, reset, gate and register stimulus,
// result back-pressure and the verdict. Depends on swgf_pkg, swgf_if.sv,
// the core and swgf_flag_checker.
module tb_sliding_window_glitch_flagger_core;
    timeunit 1ns;
    timeprecision 1ps;

    import swgf_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 85;

    logic clk;
    logic rst_n;
    int   cycles = 0;
    int   fail_count;
    int   pending;
    int   burst_left;
    logic signed [15:0] cur_bad;

    swgf_gate_if #(.SAMPLE_BITS(16)) gate_ch ();
    swgf_result_if                   res_ch ();
    swgf_cfg_if #(.DATA_W(16))       cfg_ch ();

    sliding_window_glitch_flagger_core #(
        .MAX_RADIUS (15),
        .SAMPLE_BITS(16)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .gate  (gate_ch),
        .result(res_ch),
        .cfg   (cfg_ch)
    );

    swgf_flag_checker #(
        .MAX_RADIUS(15)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .gate_valid      (gate_ch.valid),
        .gate_ready      (gate_ch.ready),
        .gate_sample     (gate_ch.sample),
        .gate_in_boundary(gate_ch.in_boundary),
        .gate_ray_start  (gate_ch.ray_start),
        .result_valid    (res_ch.valid),
        .result_ready    (res_ch.ready),
        .result_flagged  (res_ch.flagged),
        .result_tested   (res_ch.tested),
        .cfg_valid       (cfg_ch.valid),
        .cfg_ready       (cfg_ch.ready),
        .cfg_index       (cfg_ch.index),
        .cfg_data        (cfg_ch.data),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic signed [15:0] clamp16(input int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    // sample ready at the falling edge, where it is settled
    task automatic wait_taken(input bit on_cfg);
        logic hit;
        hit = 1'b0;
        while (!hit)
        begin
            @(negedge clk);
            hit = on_cfg ? cfg_ch.ready : gate_ch.ready;
            @(posedge clk);
        end
    endtask

    task automatic send_gate(input logic signed [15:0] s, input logic inb, input logic rs);
        gate_ch.valid       <= 1'b1;
        gate_ch.sample      <= s;
        gate_ch.in_boundary <= inb;
        gate_ch.ray_start   <= rs;
        wait_taken(1'b0);
        if (burst_left == 0)
        begin
            gate_ch.valid <= 1'b0;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(5, 20)) @(posedge clk);
            else
                repeat ($urandom_range(1, 3)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        else
            burst_left--;
    endtask

    task automatic write_reg(input swgf_reg_t idx, input logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        wait_taken(1'b1);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // hold until every expected result has arrived
    task automatic drain();
        gate_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int mode;
        int span;
        int tick;
        res_ch.ready = 1'b0;
        tick = 0;
        repeat (10) @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 300);
            repeat (span)
            begin
                @(posedge clk);
                tick++;
                case (mode)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= 1'($urandom_range(0, 1));
                    2:       res_ch.ready <= ($urandom_range(0, 7) != 0);
                    default: res_ch.ready <= ((tick % 12) >= 9);
                endcase
            end
        end
    end

    initial
    begin
        int                 seg_left;
        int                 base;
        int                 amp;
        int                 pick;
        logic [15:0]        thr;
        logic [3:0]         rad;
        logic [4:0]         mg;
        logic signed [15:0] s;
        logic               inb;
        logic               rs;

        gate_ch.valid       = 1'b0;
        gate_ch.sample      = '0;
        gate_ch.in_boundary = 1'b0;
        gate_ch.ray_start   = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_BAD_VALUE;
        cfg_ch.data         = '0;
        rst_n               = 1'b0;
        burst_left          = 0;
        seg_left            = 0;
        base                = 0;
        amp                 = 0;
        cur_bad             = 16'sh8000;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: full window of seven, zero threshold
        send_gate(16'sd100, 1'b1, 1'b1);
        send_gate(16'sd100, 1'b1, 1'b0);
        send_gate(16'sd100, 1'b1, 1'b0);
        send_gate(16'sh7fff, 1'b1, 1'b0);
        send_gate(16'sd100, 1'b1, 1'b0);
        send_gate(16'sd100, 1'b1, 1'b0);
        send_gate(16'sd100, 1'b1, 1'b0);
        send_gate(16'sd100, 1'b1, 1'b0);
        send_gate(16'sh8000, 1'b1, 1'b0);
        send_gate(-16'sd32767, 1'b1, 1'b0);
        send_gate(16'sd0, 1'b1, 1'b0);
        send_gate(16'sd5, 1'b0, 1'b0);
        send_gate(-16'sd1, 1'b1, 1'b0);
        send_gate(-16'sd1, 1'b1, 1'b0);
        send_gate(16'sh7fff, 1'b0, 1'b1);
        send_gate(16'sd7, 1'b1, 1'b1);

        // lone good sample in a window of three
        drain();
        write_reg(REG_RADIUS, 16'd1);
        write_reg(REG_MIN_GOOD, 16'd1);
        send_gate(16'sh8000, 1'b1, 1'b1);
        send_gate(16'sd55, 1'b1, 1'b0);
        send_gate(16'sh8000, 1'b1, 1'b0);
        send_gate(16'sh8000, 1'b1, 1'b0);
        send_gate(16'sd55, 1'b1, 1'b0);
        send_gate(16'sd55, 1'b1, 1'b0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            rad = (ph == 0) ? 4'd0 : (ph == 1) ? 4'd15 : (ph == 2) ? 4'd1
                                                                 : 4'($urandom_range(0, 15));
            mg  = (ph == 0) ? 5'd31 : (ph == 1) ? 5'd1 : (ph == 2) ? 5'd0
                                                                   : 5'($urandom_range(0, 31));
            case ($urandom_range(0, 3))
                0:       thr = 16'd0;
                1:       thr = 16'hffff;
                2:       thr = 16'($urandom_range(0, 300));
                default: thr = 16'($urandom_range(0, 6000));
            endcase
            if (ph == 0)
                thr = 16'd0;
            if (ph == 1)
                thr = 16'hffff;
            case ($urandom_range(0, 3))
                0:       cur_bad = 16'sh8000;
                1:       cur_bad = 16'sh7fff;
                2:       cur_bad = 16'sd0;
                default: cur_bad = 16'($urandom);
            endcase
            write_reg(REG_BAD_VALUE, cur_bad);
            write_reg(REG_THRESHOLD, thr);
            if (ph < 3 || $urandom_range(0, 1) == 1)
                write_reg(REG_RADIUS, {12'd0, rad});
            write_reg(REG_MIN_GOOD, {11'd0, mg});

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                rs  = 1'b0;
                inb = 1'b1;
                if (seg_left == 0)
                begin
                    rs       = 1'b1;
                    seg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                           : $urandom_range(3, 40);
                    base     = int'($urandom_range(0, 60000)) - 30000;
                    amp      = $urandom_range(0, 400);
                end
                seg_left--;
                pick = $urandom_range(0, 99);
                if (pick < 3)
                begin
                    inb = 1'b0;
                    s   = 16'($urandom);
                end
                else if (pick < 9)
                    s = cur_bad;
                else if (pick < 17)
                    s = clamp16(base + (($urandom_range(0, 1) == 1) ? 1 : -1)
                                       * int'($urandom_range(500, 30000)));
                else if (pick < 22)
                    s = 16'($urandom);
                else
                    s = clamp16(base + int'($urandom_range(0, 2 * amp)) - amp);
                // stray or missing ray start
                if ($urandom_range(0, 99) == 0)
                    rs = ~rs;
                send_gate(s, inb, rs);
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/swgf_pkg.sv
rtl/swgf_if.sv
rtl/sliding_window_glitch_flagger_core.sv
tb/swgf_flag_checker.sv
tb/tb_sliding_window_glitch_flagger_core.sv
